// File: rtl/dsa_pkg.sv
package dsa_pkg;

  localparam int FRAC_BITS = 24;

  // settle window, round(0.002 * 2^FRAC_BITS)
  localparam logic [32:0] SETTLE_THR = 33'(((2 << FRAC_BITS) + 500) / 1000);

  localparam logic [31:0] MAX_ELAPSED = 32'd1000;
  localparam logic [31:0] TICK_MS     = 32'd4;

  // num / 100000 = (|num| >> 5) / 3125, the latter by exact reciprocal
  localparam int          PRE_SHIFT = 5;
  localparam int          DIV_SHIFT = 60;
  localparam logic [48:0] DIV_M     = 49'(((64'd1 << DIV_SHIFT) + 64'd3124) / 64'd3125);

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = 60;
  localparam int ACC_W   = 100;

  typedef enum logic [2:0] {
    REG_SPRING_K   = 3'd0,
    REG_FRICTION   = 3'd1,
    REG_TARGET     = 3'd2,
    REG_CLIP_MODE  = 3'd3,
    REG_LOWER      = 3'd4,
    REG_UPPER      = 3'd5,
    REG_START_VAL  = 3'd6,
    REG_START_PREV = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLIP_FREE   = 2'd0,
    CLIP_CLAMP  = 2'd1,
    CLIP_BOUNCE = 2'd2
  } clip_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_K,
    ST_MUL_F,
    ST_NUM,
    ST_PP_LL,
    ST_PP_LH,
    ST_PP_HL,
    ST_PP_HH,
    ST_ACC,
    ST_NEW,
    ST_CLIP,
    ST_RESULT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RESTART,
    OP_ADVANCE,
    OP_MUL_K,
    OP_MUL_F,
    OP_NUM,
    OP_PP_LL,
    OP_PP_LH,
    OP_PP_HL,
    OP_PP_HH,
    OP_ACC,
    OP_NEW,
    OP_CLIP,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic more_ticks;
  } dp_status_t;

endpackage

// File: rtl/damped_spring_animator_unit.sv
// restart word: loads the start position and time, then registers the result in ST_RESULT
// advance word: runs one tick per 4 ms of elapsed time, at most 249 ticks, then registers the result;
//   each tick steps ST_MUL_K through ST_CLIP on one shared 34x25 multiplier
// one word in flight; a new word is taken while the last result waits
// rst_n (synchronous, active low) sets config to defaults and positions and time to zero
module damped_spring_animator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // time_ms[31:0]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // position[31:0], settled[32], ticks_run[40:33],
                                  // time_jump[41], zero[47:42]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  dsa_pkg::dp_cmd_t    cmd;
  dsa_pkg::dp_status_t status;
  logic [31:0]         res_position;
  logic                res_settled;
  logic [7:0]          res_ticks;
  logic                res_jump;

  dsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  dsa_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .in_time      (in_tdata),
    .status       (status),
    .res_position (res_position),
    .res_settled  (res_settled),
    .res_ticks    (res_ticks),
    .res_jump     (res_jump)
  );

  assign out_tdata = {6'd0, res_jump, res_ticks, res_settled, res_position};

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");

  a_ticks_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[40:33] <= 8'd249)
    else $error("tick count beyond limit");

  a_jump_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[41] |-> out_tdata[40:33] == 8'd249)
    else $error("clamped gap did not run full tick count");

endmodule

// File: rtl/dsa_datapath.sv
module dsa_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [31:0]          cfg_wdata,
  input  dsa_pkg::dp_cmd_t     cmd,
  input  logic [31:0]          in_time,
  output dsa_pkg::dp_status_t  status,
  output logic [31:0]          res_position,
  output logic                 res_settled,
  output logic [7:0]           res_ticks,
  output logic                 res_jump
);

  localparam int PROD_W_L = dsa_pkg::PROD_W;

  // configuration
  logic [15:0] k_r;
  logic [15:0] f_r;
  logic [31:0] target_r;
  logic [1:0]  clip_r;
  logic [31:0] lo_r;
  logic [31:0] hi_r;
  logic [31:0] sv_r;
  logic [31:0] sp_r;

  // spring state
  logic [31:0] cur_pos_r;
  logic [31:0] prev_pos_r;
  logic [31:0] last_r;
  logic [31:0] now_r;
  logic [7:0]  ticks_r;
  logic        jump_r;

  // tick working registers
  logic signed [PROD_W_L-1:0] prod_r;
  logic [dsa_pkg::ACC_W-1:0]  acc_r;
  logic [47:0]                n1_r;
  logic                       neg_r;
  logic [31:0]                new_r;

  // output word
  logic [31:0] pos_out_r;
  logic        settled_out_r;
  logic [7:0]  ticks_out_r;
  logic        jump_out_r;

  logic signed [dsa_pkg::MUL_A_W-1:0] mul_a;
  logic [dsa_pkg::MUL_B_W-1:0]        mul_b;
  logic signed [dsa_pkg::MUL_B_W:0]   mul_bs;
  logic signed [PROD_W_L-1:0]         mul_p;

  logic [16:0]        f_inc;
  logic [20:0]        kf;
  logic signed [32:0] tc_diff;
  logic signed [32:0] vel;
  logic signed [PROD_W_L-1:0] num;
  logic signed [PROD_W_L-1:0] mag;
  logic [39:0]        quo;
  logic signed [40:0] quo_s;
  logic signed [41:0] nc;
  logic [31:0]        elapsed;
  logic [31:0]        elapsed_now;

  logic [31:0]        clip_cur;
  logic [31:0]        clip_prv;
  logic signed [33:0] refl_cur;
  logic signed [33:0] refl_prv;
  logic signed [33:0] refl_base;

  logic signed [32:0] dc;
  logic signed [32:0] dp;
  logic [32:0]        adc;
  logic [32:0]        adp;

  function automatic logic [31:0] sat42(input logic signed [41:0] v);
    logic ovf;
    ovf = (v[41:31] != {11{v[41]}});
    if (ovf) begin
      sat42 = v[41] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      sat42 = v[31:0];
    end
  endfunction

  // multiplier operand selection
  assign f_inc   = {1'b0, f_r} + 17'd1;
  assign kf      = {1'b0, f_inc, 3'b000} + {3'b000, f_inc, 1'b0};
  assign tc_diff = $signed({target_r[31], target_r}) - $signed({cur_pos_r[31], cur_pos_r});
  assign vel     = $signed({cur_pos_r[31], cur_pos_r}) - $signed({prev_pos_r[31], prev_pos_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      dsa_pkg::OP_MUL_K: begin
        mul_a = dsa_pkg::MUL_A_W'(tc_diff);
        mul_b = dsa_pkg::MUL_B_W'(k_r);
      end
      dsa_pkg::OP_MUL_F: begin
        mul_a = dsa_pkg::MUL_A_W'(vel);
        mul_b = dsa_pkg::MUL_B_W'(kf);
      end
      dsa_pkg::OP_PP_LL: begin
        mul_a = dsa_pkg::MUL_A_W'(n1_r[24:0]);
        mul_b = dsa_pkg::DIV_M[24:0];
      end
      dsa_pkg::OP_PP_LH: begin
        mul_a = dsa_pkg::MUL_A_W'(n1_r[24:0]);
        mul_b = dsa_pkg::MUL_B_W'(dsa_pkg::DIV_M[48:25]);
      end
      dsa_pkg::OP_PP_HL: begin
        mul_a = dsa_pkg::MUL_A_W'(n1_r[47:25]);
        mul_b = dsa_pkg::DIV_M[24:0];
      end
      dsa_pkg::OP_PP_HH: begin
        mul_a = dsa_pkg::MUL_A_W'(n1_r[47:25]);
        mul_b = dsa_pkg::MUL_B_W'(dsa_pkg::DIV_M[48:25]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_bs = $signed({1'b0, mul_b});
  assign mul_p  = PROD_W_L'(mul_a) * PROD_W_L'(mul_bs);

  // force numerator, quotient and new position
  assign num   = $signed(acc_r[PROD_W_L-1:0]) - prod_r;
  assign mag   = num[PROD_W_L-1] ? -num : num;
  assign quo   = acc_r[dsa_pkg::ACC_W-1:dsa_pkg::DIV_SHIFT];
  assign quo_s = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign nc    = 42'($signed({cur_pos_r[31], cur_pos_r, 1'b0}))
               - 42'($signed(prev_pos_r)) + 42'(quo_s);

  // clip rule
  assign refl_base = dsa_pkg::clip_mode_t'(clip_r) == dsa_pkg::CLIP_BOUNCE &&
                     $signed(new_r) > $signed(hi_r) ?
                     $signed({hi_r[31], hi_r, 1'b0}) : $signed({lo_r[31], lo_r, 1'b0});
  assign refl_cur  = refl_base - 34'($signed(new_r));
  assign refl_prv  = refl_base - 34'($signed(cur_pos_r));

  always_comb begin
    clip_cur = new_r;
    clip_prv = cur_pos_r;
    case (dsa_pkg::clip_mode_t'(clip_r))
      dsa_pkg::CLIP_CLAMP: begin
        if ($signed(new_r) > $signed(hi_r)) begin
          clip_cur = hi_r;
          clip_prv = hi_r;
        end else if ($signed(new_r) < $signed(lo_r)) begin
          clip_cur = lo_r;
          clip_prv = lo_r;
        end
      end
      dsa_pkg::CLIP_BOUNCE: begin
        if ($signed(new_r) > $signed(hi_r) || $signed(new_r) < $signed(lo_r)) begin
          clip_cur = sat42(42'(refl_cur));
          clip_prv = sat42(42'(refl_prv));
        end
      end
      default: begin
        clip_cur = new_r;
        clip_prv = cur_pos_r;
      end
    endcase
  end

  // time keeping
  assign elapsed     = in_time - last_r;
  assign elapsed_now = now_r - last_r;
  assign status.more_ticks = elapsed_now > dsa_pkg::TICK_MS;

  // settle test
  assign dc  = $signed({cur_pos_r[31], cur_pos_r}) - $signed({target_r[31], target_r});
  assign dp  = $signed({prev_pos_r[31], prev_pos_r}) - $signed({target_r[31], target_r});
  assign adc = dc[32] ? 33'(-dc) : 33'(dc);
  assign adp = dp[32] ? 33'(-dp) : 33'(dp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r      <= 16'd200;
      f_r      <= 16'd400;
      target_r <= 32'h0100_0000;
      clip_r   <= dsa_pkg::CLIP_FREE;
      lo_r     <= 32'd0;
      hi_r     <= 32'h0100_0000;
      sv_r     <= 32'd0;
      sp_r     <= 32'd0;
    end else if (cfg_we) begin
      case (dsa_pkg::cfg_reg_t'(cfg_addr))
        dsa_pkg::REG_SPRING_K:   k_r      <= cfg_wdata[15:0];
        dsa_pkg::REG_FRICTION:   f_r      <= cfg_wdata[15:0];
        dsa_pkg::REG_TARGET:     target_r <= cfg_wdata;
        dsa_pkg::REG_CLIP_MODE:  clip_r   <= cfg_wdata[1:0];
        dsa_pkg::REG_LOWER:      lo_r     <= cfg_wdata;
        dsa_pkg::REG_UPPER:      hi_r     <= cfg_wdata;
        dsa_pkg::REG_START_VAL:  sv_r     <= cfg_wdata;
        dsa_pkg::REG_START_PREV: sp_r     <= cfg_wdata;
        default: k_r <= k_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pos_r  <= 32'd0;
      prev_pos_r <= 32'd0;
      last_r     <= 32'd0;
    end else begin
      case (cmd.op)
        dsa_pkg::OP_RESTART: begin
          cur_pos_r  <= sv_r;
          prev_pos_r <= sp_r;
          last_r     <= in_time;
        end
        dsa_pkg::OP_ADVANCE: begin
          if (elapsed > dsa_pkg::MAX_ELAPSED) begin
            last_r <= in_time - dsa_pkg::MAX_ELAPSED;
          end
        end
        dsa_pkg::OP_CLIP: begin
          cur_pos_r  <= clip_cur;
          prev_pos_r <= clip_prv;
          last_r     <= last_r + dsa_pkg::TICK_MS;
        end
        default: begin
          cur_pos_r <= cur_pos_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      dsa_pkg::OP_RESTART: begin
        now_r   <= in_time;
        ticks_r <= 8'd0;
        jump_r  <= 1'b0;
      end
      dsa_pkg::OP_ADVANCE: begin
        now_r   <= in_time;
        ticks_r <= 8'd0;
        jump_r  <= elapsed > dsa_pkg::MAX_ELAPSED;
      end
      dsa_pkg::OP_MUL_K: begin
        prod_r <= mul_p;
      end
      dsa_pkg::OP_MUL_F: begin
        prod_r <= mul_p;
        acc_r  <= dsa_pkg::ACC_W'(prod_r);
      end
      dsa_pkg::OP_NUM: begin
        neg_r <= num[PROD_W_L-1];
        n1_r  <= mag[47+dsa_pkg::PRE_SHIFT:dsa_pkg::PRE_SHIFT];
      end
      dsa_pkg::OP_PP_LL: begin
        prod_r <= mul_p;
      end
      dsa_pkg::OP_PP_LH: begin
        prod_r <= mul_p;
        acc_r  <= dsa_pkg::ACC_W'(prod_r[49:0]);
      end
      dsa_pkg::OP_PP_HL: begin
        prod_r <= mul_p;
        acc_r  <= acc_r + (dsa_pkg::ACC_W'(prod_r[49:0]) << 25);
      end
      dsa_pkg::OP_PP_HH: begin
        prod_r <= mul_p;
        acc_r  <= acc_r + (dsa_pkg::ACC_W'(prod_r[49:0]) << 25);
      end
      dsa_pkg::OP_ACC: begin
        acc_r <= acc_r + (dsa_pkg::ACC_W'(prod_r[49:0]) << 50);
      end
      dsa_pkg::OP_NEW: begin
        new_r <= sat42(nc);
      end
      dsa_pkg::OP_CLIP: begin
        ticks_r <= ticks_r + 8'd1;
      end
      dsa_pkg::OP_RESULT: begin
        pos_out_r     <= cur_pos_r;
        settled_out_r <= (adc < dsa_pkg::SETTLE_THR) && (adp < dsa_pkg::SETTLE_THR);
        ticks_out_r   <= ticks_r;
        jump_out_r    <= jump_r;
      end
      default: begin
        now_r <= now_r;
      end
    endcase
  end

  assign res_position = pos_out_r;
  assign res_settled  = settled_out_r;
  assign res_ticks    = ticks_out_r;
  assign res_jump     = jump_out_r;

endmodule

// File: rtl/dsa_ctrl.sv
module dsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_mode,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  dsa_pkg::dp_status_t status,
  output dsa_pkg::dp_cmd_t    cmd
);

  dsa_pkg::ctrl_state_t state_r;
  dsa_pkg::ctrl_state_t state_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd.op        = dsa_pkg::OP_NONE;
    case (state_r)
      dsa_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_mode) begin
            cmd.op    = dsa_pkg::OP_ADVANCE;
            state_nxt = dsa_pkg::ST_CHECK;
          end else begin
            cmd.op    = dsa_pkg::OP_RESTART;
            state_nxt = dsa_pkg::ST_RESULT;
          end
        end
      end
      dsa_pkg::ST_CHECK: begin
        state_nxt = status.more_ticks ? dsa_pkg::ST_MUL_K : dsa_pkg::ST_RESULT;
      end
      dsa_pkg::ST_MUL_K: begin
        cmd.op    = dsa_pkg::OP_MUL_K;
        state_nxt = dsa_pkg::ST_MUL_F;
      end
      dsa_pkg::ST_MUL_F: begin
        cmd.op    = dsa_pkg::OP_MUL_F;
        state_nxt = dsa_pkg::ST_NUM;
      end
      dsa_pkg::ST_NUM: begin
        cmd.op    = dsa_pkg::OP_NUM;
        state_nxt = dsa_pkg::ST_PP_LL;
      end
      dsa_pkg::ST_PP_LL: begin
        cmd.op    = dsa_pkg::OP_PP_LL;
        state_nxt = dsa_pkg::ST_PP_LH;
      end
      dsa_pkg::ST_PP_LH: begin
        cmd.op    = dsa_pkg::OP_PP_LH;
        state_nxt = dsa_pkg::ST_PP_HL;
      end
      dsa_pkg::ST_PP_HL: begin
        cmd.op    = dsa_pkg::OP_PP_HL;
        state_nxt = dsa_pkg::ST_PP_HH;
      end
      dsa_pkg::ST_PP_HH: begin
        cmd.op    = dsa_pkg::OP_PP_HH;
        state_nxt = dsa_pkg::ST_ACC;
      end
      dsa_pkg::ST_ACC: begin
        cmd.op    = dsa_pkg::OP_ACC;
        state_nxt = dsa_pkg::ST_NEW;
      end
      dsa_pkg::ST_NEW: begin
        cmd.op    = dsa_pkg::OP_NEW;
        state_nxt = dsa_pkg::ST_CLIP;
      end
      dsa_pkg::ST_CLIP: begin
        cmd.op    = dsa_pkg::OP_CLIP;
        state_nxt = dsa_pkg::ST_CHECK;
      end
      dsa_pkg::ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = dsa_pkg::OP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = dsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dsa_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// File: sim/tb.sv
module tb;

  localparam logic MODE_RESTART = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;
  localparam logic [1:0] CLIP_UNUSED = 2'd3;

  localparam logic signed [31:0] Q_ONE  = 32'sh0100_0000;
  localparam logic signed [31:0] Q_HALF = 32'sh0080_0000;
  localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
  localparam longint SETTLE_WIN = ((64'sd2 << dsa_pkg::FRAC_BITS) + 500) / 1000;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_WORDS   = 525;
  localparam int PHASE_WORDS    = 66;
  localparam int SETTLE_GAP     = 8;

  typedef struct packed {
    logic [15:0]        k;
    logic [15:0]        f;
    logic signed [31:0] target;
    logic [1:0]         clip;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] sv;
    logic signed [31:0] sp;
  } spring_cfg_t;

  // result word layout, lowest bits last
  typedef struct packed {
    logic [5:0]         pad;
    logic               jump;
    logic [7:0]         ticks;
    logic               settled;
    logic signed [31:0] pos;
  } spring_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  damped_spring_animator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // spring model state
  spring_cfg_t        spring_cfg;
  logic signed [31:0] cur_pos;
  logic signed [31:0] prev_pos;
  logic [31:0]        last_ms;
  logic [31:0]        clock_ms;

  spring_word_t expected_q[$];
  int  mismatches      = 0;
  int  words_sent      = 0;
  int  results_checked = 0;
  int  settled_seen    = 0;
  int  jumps_seen      = 0;
  int  cfg_settings    = 0;
  int  idle_cycles     = 0;
  bit  src_idle_on     = 1'b1;
  bit  snk_idle_on     = 1'b1;
  bit  hold_pending    = 1'b0;

  function automatic spring_cfg_t reset_cfg();
    spring_cfg_t c;
    c.k      = 16'd200;
    c.f      = 16'd400;
    c.target = Q_ONE;
    c.clip   = dsa_pkg::CLIP_FREE;
    c.lo     = '0;
    c.hi     = Q_ONE;
    c.sv     = '0;
    c.sp     = '0;
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic void spring_tick();
    longint c, p, t, lo, hi, v, num;
    logic signed [31:0] nxt, prv;
    c   = longint'(cur_pos);
    p   = longint'(prev_pos);
    t   = longint'($signed(spring_cfg.target));
    lo  = longint'($signed(spring_cfg.lo));
    hi  = longint'($signed(spring_cfg.hi));
    v   = c - p;
    num = longint'(spring_cfg.k) * (t - c) - v * 10 * (longint'(spring_cfg.f) + 1);
    nxt = sat32(2 * c - p + num / 100000);
    prv = cur_pos;
    if (spring_cfg.clip == dsa_pkg::CLIP_CLAMP) begin
      if (longint'(nxt) > hi) begin
        nxt = hi[31:0];
        prv = hi[31:0];
      end else if (longint'(nxt) < lo) begin
        nxt = lo[31:0];
        prv = lo[31:0];
      end
    end else if (spring_cfg.clip == dsa_pkg::CLIP_BOUNCE) begin
      if (longint'(nxt) > hi) begin
        nxt = sat32(2 * hi - longint'(nxt));
        prv = sat32(2 * hi - longint'(prv));
      end else if (longint'(nxt) < lo) begin
        nxt = sat32(2 * lo - longint'(nxt));
        prv = sat32(2 * lo - longint'(prv));
      end
    end
    cur_pos  = nxt;
    prev_pos = prv;
  endfunction

  function automatic spring_word_t spring_step(logic mode, logic [31:0] now);
    spring_word_t r;
    longint       tg, dc, dp;
    logic [31:0]  el;
    r = '0;
    if (mode == MODE_RESTART) begin
      cur_pos  = spring_cfg.sv;
      prev_pos = spring_cfg.sp;
      last_ms  = now;
    end else begin
      el = now - last_ms;
      if (el > dsa_pkg::MAX_ELAPSED) begin
        last_ms = now - dsa_pkg::MAX_ELAPSED;
        r.jump  = 1'b1;
      end
      el = now - last_ms;
      while (el > dsa_pkg::TICK_MS) begin
        spring_tick();
        r.ticks = r.ticks + 8'd1;
        last_ms = last_ms + dsa_pkg::TICK_MS;
        el      = now - last_ms;
      end
    end
    tg = longint'($signed(spring_cfg.target));
    dc = longint'(cur_pos) - tg;
    dp = longint'(prev_pos) - tg;
    if (dc < 0) dc = -dc;
    if (dp < 0) dp = -dp;
    r.settled = (dc < SETTLE_WIN) && (dp < SETTLE_WIN);
    r.pos     = cur_pos;
    return r;
  endfunction

  // stimulus side

  task automatic send_word(input logic mode, input logic [31:0] now);
    while (src_idle_on && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= now;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(spring_step(mode, now));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic restart_at(input logic [31:0] now);
    clock_ms = now;
    send_word(MODE_RESTART, now);
  endtask

  task automatic advance_by(input logic [31:0] el);
    clock_ms = clock_ms + el;
    send_word(MODE_ADVANCE, clock_ms);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic apply_cfg(input spring_cfg_t c);
    dsa_pkg::cfg_reg_t r;
    logic [31:0]       v;
    for (int i = 0; i < 8; i++) begin
      r = dsa_pkg::cfg_reg_t'(i);
      case (r)
        dsa_pkg::REG_SPRING_K:  v = {16'($urandom()), c.k};
        dsa_pkg::REG_FRICTION:  v = {16'($urandom()), c.f};
        dsa_pkg::REG_TARGET:    v = c.target;
        dsa_pkg::REG_CLIP_MODE: v = {30'($urandom()), c.clip};
        dsa_pkg::REG_LOWER:     v = c.lo;
        dsa_pkg::REG_UPPER:     v = c.hi;
        dsa_pkg::REG_START_VAL: v = c.sv;
        default:                v = c.sp;
      endcase
      cfg_we    <= 1'b1;
      cfg_addr  <= r;
      cfg_wdata <= v;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    spring_cfg = c;
    cfg_settings++;
  endtask

  function automatic logic signed [31:0] around(logic signed [31:0] base, int unsigned span);
    return base + 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom());
      default: return 16'($urandom_range(1, 1000));
    endcase
  endfunction

  function automatic spring_cfg_t random_cfg();
    spring_cfg_t c;
    c.k      = pick_gain();
    c.f      = pick_gain();
    c.target = ($urandom_range(3) == 0) ? 32'($urandom()) : around('0, 4 * Q_ONE);
    c.clip   = 2'($urandom_range(3));
    c.lo     = around(c.target - Q_ONE, Q_ONE);
    c.hi     = around(c.target + Q_ONE, Q_ONE);
    if ($urandom_range(5) == 0) begin
      c.lo = $urandom();
      c.hi = $urandom();
    end
    c.sv = around(c.target, 2 * Q_ONE);
    c.sp = around(c.sv, Q_ONE / 16);
    case ($urandom_range(7))
      0: begin
        c.sv = $urandom();
        c.sp = $urandom();
      end
      1, 2: begin
        c.sv = around(c.target, 40000);
        c.sp = around(c.target, 40000);
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] random_elapsed();
    case ($urandom_range(19))
      0:       return $urandom();
      1:       return $urandom_range(1001, 5000);
      2, 3:    return $urandom_range(41, 1000);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  // tests

  task automatic test_timing();
    advance_by(50);
    restart_at(32'hFFFF_FFF0);
    advance_by(20);
    advance_by(0);
    advance_by(4);
    advance_by(5);
    advance_by(1000);
    advance_by(1001);
    advance_by(32'hFFFF_FFF6);
  endtask

  task automatic test_extremes();
    spring_cfg_t c;
    wait_idle();
    c        = reset_cfg();
    c.k      = 16'hFFFF;
    c.f      = 16'd0;
    c.target = Q_MAX;
    c.sv     = Q_MIN;
    c.sp     = Q_MAX;
    apply_cfg(c);
    restart_at($urandom());
    advance_by(40);
    wait_idle();
    c.k      = 16'd0;
    c.f      = 16'hFFFF;
    c.target = Q_MIN;
    c.clip   = CLIP_UNUSED;
    c.sv     = Q_MAX;
    c.sp     = Q_MIN;
    apply_cfg(c);
    restart_at($urandom());
    advance_by(40);
  endtask

  task automatic test_clamp();
    spring_cfg_t c;
    wait_idle();
    c        = reset_cfg();
    c.clip   = dsa_pkg::CLIP_CLAMP;
    c.lo     = -Q_HALF;
    c.hi     = Q_HALF;
    c.target = 2 * Q_ONE;
    apply_cfg(c);
    restart_at(clock_ms);
    advance_by(200);
    wait_idle();
    c.target = -2 * Q_ONE;
    apply_cfg(c);
    restart_at(clock_ms);
    advance_by(200);
    // inverted bounds
    wait_idle();
    c.lo = Q_ONE;
    c.hi = -Q_ONE;
    apply_cfg(c);
    restart_at(clock_ms);
    advance_by(20);
  endtask

  task automatic test_bounce();
    spring_cfg_t c;
    wait_idle();
    c        = reset_cfg();
    c.clip   = dsa_pkg::CLIP_BOUNCE;
    c.lo     = -Q_ONE;
    c.hi     = Q_ONE;
    c.target = 3 * Q_ONE;
    apply_cfg(c);
    restart_at(clock_ms);
    advance_by(400);
    // reflection past the top of the range
    wait_idle();
    c.hi     = Q_MAX - 15;
    c.lo     = Q_MIN + 16;
    c.target = Q_MAX;
    c.sv     = 32'sh7FFF_0000;
    c.sp     = '0;
    apply_cfg(c);
    restart_at(clock_ms);
    advance_by(20);
  endtask

  task automatic test_settle();
    spring_cfg_t c;
    wait_idle();
    c    = reset_cfg();
    c.sv = c.target + 32'(SETTLE_WIN) - 1;
    c.sp = c.target - 32'(SETTLE_WIN) + 1;
    apply_cfg(c);
    restart_at(clock_ms);
    wait_idle();
    c.sv = c.target + 32'(SETTLE_WIN);
    apply_cfg(c);
    restart_at(clock_ms);
  endtask

  task automatic test_random();
    int phase;
    int first_word;
    int phase_word;
    phase      = 0;
    first_word = words_sent;
    while (words_sent - first_word < RANDOM_WORDS) begin
      wait_idle();
      apply_cfg(random_cfg());
      src_idle_on = (phase != 2);
      snk_idle_on = (phase != 2);
      if (phase == 4) hold_pending = 1'b1;
      phase_word = words_sent;
      while (words_sent - phase_word < PHASE_WORDS) begin
        if ($urandom_range(4) != 0) restart_at($urandom());
        repeat ($urandom_range(1, 12)) advance_by(random_elapsed());
        if ($urandom_range(7) == 0) wait_idle();
      end
      phase++;
    end
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  // result side

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= snk_idle_on ? ($urandom_range(99) >= 36) : 1'b1;
    end
  end

  task automatic cmp_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    spring_word_t got;
    spring_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_q.size() == 0) begin
        $error("result word %h with nothing expected", got);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        cmp_field("position", longint'($signed(want.pos)), longint'($signed(got.pos)));
        cmp_field("settled", want.settled, got.settled);
        cmp_field("ticks_run", want.ticks, got.ticks);
        cmp_field("time_jump", want.jump, got.jump);
        cmp_field("pad", want.pad, got.pad);
        results_checked++;
        settled_seen += want.settled;
        jumps_seen   += want.jump;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = MODE_RESTART;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_addr   = dsa_pkg::REG_SPRING_K;
    cfg_wdata  = '0;
    spring_cfg = reset_cfg();
    cur_pos    = '0;
    prev_pos   = '0;
    last_ms    = '0;
    clock_ms   = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_timing();
    test_extremes();
    test_clamp();
    test_bounce();
    test_settle();
    test_random();

    wait_idle();
    repeat (50) @(negedge clk);
    $display("run: %0d words sent, %0d results checked, %0d config settings",
             words_sent, results_checked, cfg_settings);
    $display("run: %0d settled results, %0d clamped time jumps, %0d mismatches",
             settled_seen, jumps_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
